// File: design/lbsa_pkg.sv
// shared types and constants for the log band spectrum average block
package lbsa_pkg;

    localparam int unsigned LOG_W = 20;
    localparam int unsigned DIVD_W = 27;
    localparam int unsigned DIVS_W = 20;
    localparam int unsigned CNT_W = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BAR_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_HIGH = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  bar_index;
        logic [15:0] bar_value;
        logic [15:0] edge_a_hz;
        logic [15:0] edge_b_hz;
        logic        spectrum_valid;
    } t_in_item;

    typedef struct packed {
        logic [15:0] band_level;
        logic        status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LMIN,
        S_LMAX,
        S_LLO,
        S_DLO,
        S_LHI,
        S_DHI,
        S_SUM,
        S_MEAN
    } t_state;

    typedef enum logic [1:0] {
        LOG_FMIN,
        LOG_FMAX,
        LOG_LO,
        LOG_HI
    } t_log_sel;

    typedef enum logic {
        DIV_EDGE,
        DIV_MEAN
    } t_div_sel;

    typedef struct packed {
        logic     wr_bar;
        logic     capture;
        logic     log_start;
        t_log_sel log_sel;
        logic     lmin_latch;
        logic     den_latch;
        logic     div_start;
        t_div_sel div_sel;
        logic     b0_latch;
        logic     b1_latch;
        logic     sum_init;
        logic     emit;
        logic     emit_err;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_query;
        logic query_err;
        logic log_done;
        logic den_zero;
        logic div_done;
        logic sum_done;
    } t_ctl_stat;

endpackage

// File: design/lbsa_log2.sv
// iterative floor(log2(x)*65536) unit built on one shared 32x32 multiplier
module lbsa_log2
    import lbsa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [15:0]      i_x,
    output logic             o_done,
    output logic [LOG_W-1:0] o_result
);

    logic         r_busy;
    logic [1:0]   r_ph;
    logic [3:0]   r_k;
    logic [3:0]   r_msb;
    logic [15:0]  r_frac;
    logic [63:0]  r_mant;
    logic [127:0] r_acc;
    logic         r_done;

    logic [3:0]   msb;
    logic [31:0]  op_a;
    logic [31:0]  op_b;
    logic [63:0]  prod;
    logic [127:0] term;
    logic [127:0] n_sum;
    logic         ge2;

    // leading one of the input
    always_comb begin
        msb = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (i_x[i]) begin
                msb = 4'(i);
            end
        end
    end

    // one partial product of the mantissa square per cycle
    always_comb begin
        case (r_ph)
            2'd0: begin
                op_a = r_mant[31:0];
                op_b = r_mant[31:0];
            end
            2'd1: begin
                op_a = r_mant[31:0];
                op_b = r_mant[63:32];
            end
            default: begin
                op_a = r_mant[63:32];
                op_b = r_mant[63:32];
            end
        endcase
        prod = 64'(op_a) * 64'(op_b);
        case (r_ph)
            2'd0: begin
                term = 128'(prod);
            end
            2'd1: begin
                term = 128'(prod) << 33;
            end
            default: begin
                term = 128'(prod) << 64;
            end
        endcase
        n_sum = ((r_ph == 2'd0) ? 128'd0 : r_acc) + term;
        ge2 = n_sum[127];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph <= 2'd0;
            r_k <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph <= 2'd0;
                r_k <= 4'd0;
                r_msb <= msb;
                r_frac <= 16'd0;
                r_mant <= {i_x, 48'd0} << (4'd15 - msb);
            end else if (r_busy) begin
                r_acc <= n_sum;
                if (r_ph == 2'd2) begin
                    r_ph <= 2'd0;
                    r_mant <= ge2 ? n_sum[127:64] : n_sum[126:63];
                    r_frac <= {r_frac[14:0], ge2};
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd15) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_ph <= r_ph + 2'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_result = {r_msb, r_frac};

endmodule

// File: design/lbsa_div.sv
// restoring divider, one quotient bit per cycle
module lbsa_div
    import lbsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);

    localparam int unsigned CW = $clog2(DIVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIVD_W-1:0] r_q;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_dvs;

    logic [DIVS_W:0]   rem_sh;
    logic [DIVS_W:0]   diff;
    logic              fits;

    // shift in the next dividend bit and trial subtract
    always_comb begin
        rem_sh = {r_rem, r_q[DIVD_W-1]};
        diff = rem_sh - {1'b0, r_dvs};
        fits = rem_sh >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(DIVD_W);
                r_q <= i_dividend;
                r_rem <= '0;
                r_dvs <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
                r_q <= {r_q[DIVD_W-2:0], fits};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quotient = r_q;

endmodule

// File: design/lbsa_datapath.sv
// configuration, bar memory, edge mapping, band sum and result register
module lbsa_datapath
    import lbsa_pkg::*;
#(
    parameter int unsigned MAX_BARS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_item,
    input  t_ctl_cmd              i_cmd,
    output t_ctl_stat             o_stat,
    output logic                  o_valid,
    output t_out_item             o_result
);

    localparam int unsigned AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;

    logic [CNT_W-1:0] r_bar_count;
    logic [15:0]      r_freq_low;
    logic [15:0]      r_freq_high;

    logic [15:0]      r_mem [MAX_BARS];
    logic [15:0]      r_rdata;

    logic [15:0]      r_lo;
    logic [15:0]      r_hi;
    logic [CNT_W-1:0] r_n;
    logic [LOG_W-1:0] r_lmin;
    logic [LOG_W-1:0] r_den;
    logic [CNT_W-1:0] r_b0;
    logic [CNT_W-1:0] r_b1;
    logic [CNT_W-1:0] r_idx;
    logic             r_issuing;
    logic             r_rd_vld;
    logic [22:0]      r_sum;
    logic             r_valid;
    t_out_item        r_result;

    logic [CNT_W-1:0]  n_cur;
    logic [15:0]       e_lo;
    logic [15:0]       e_hi;
    logic [15:0]       c_lo;
    logic [15:0]       c_hi;
    logic [15:0]       log_x;
    logic              log_done;
    logic [LOG_W-1:0]  log_res;
    logic [LOG_W-1:0]  log_num;
    logic [DIVD_W-1:0] edge_prod;
    logic [DIVD_W-1:0] div_dvd;
    logic [DIVS_W-1:0] div_dvs;
    logic              div_done;
    logic [DIVD_W-1:0] div_q;
    logic [CNT_W-1:0]  edge_idx;
    logic [CNT_W-1:0]  span;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_count <= 7'd64;
            r_freq_low <= 16'd20;
            r_freq_high <= 16'd20000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BAR_COUNT: r_bar_count <= i_cfg_data[CNT_W-1:0];
                CFG_FREQ_LOW:  r_freq_low <= i_cfg_data;
                CFG_FREQ_HIGH: r_freq_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // bars in use, edge ordering and clamping
    always_comb begin
        n_cur = (32'(r_bar_count) < MAX_BARS) ? r_bar_count : CNT_W'(MAX_BARS);
        if (i_item.edge_b_hz < i_item.edge_a_hz) begin
            e_lo = i_item.edge_b_hz;
            e_hi = i_item.edge_a_hz;
        end else begin
            e_lo = i_item.edge_a_hz;
            e_hi = i_item.edge_b_hz;
        end
        c_lo = (e_lo < r_freq_low) ? r_freq_low : e_lo;
        c_lo = (c_lo > r_freq_high) ? r_freq_high : c_lo;
        c_hi = (e_hi < r_freq_low) ? r_freq_low : e_hi;
        c_hi = (c_hi > r_freq_high) ? r_freq_high : c_hi;
    end

    // logarithm operand select
    always_comb begin
        case (i_cmd.log_sel)
            LOG_FMIN: log_x = r_freq_low;
            LOG_FMAX: log_x = r_freq_high;
            LOG_LO:   log_x = r_lo;
            LOG_HI:   log_x = r_hi;
            default:  log_x = r_lo;
        endcase
    end

    lbsa_log2 u_log2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.log_start),
        .i_x      (log_x),
        .o_done   (log_done),
        .o_result (log_res)
    );

    // divider operand select: edge index or band mean
    always_comb begin
        log_num = log_res - r_lmin;
        edge_prod = DIVD_W'(r_n) * DIVD_W'(log_num);
        span = r_b1 - r_b0 + CNT_W'(1);
        case (i_cmd.div_sel)
            DIV_EDGE: begin
                div_dvd = edge_prod;
                div_dvs = r_den;
            end
            DIV_MEAN: begin
                div_dvd = DIVD_W'(r_sum);
                div_dvs = DIVS_W'(span);
            end
            default: begin
                div_dvd = edge_prod;
                div_dvs = r_den;
            end
        endcase
    end

    lbsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // index clamped below the bar count
    assign edge_idx = (div_q >= DIVD_W'(r_n)) ? (r_n - CNT_W'(1)) : div_q[CNT_W-1:0];

    // bar memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_bar && (32'(i_item.bar_index) < MAX_BARS)) begin
            r_mem[AW'(i_item.bar_index)] <= i_item.bar_value;
        end
        r_rdata <= r_mem[AW'(r_idx)];
    end

    // query operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lo <= c_lo;
            r_hi <= c_hi;
            r_n <= n_cur;
        end
        if (i_cmd.lmin_latch) begin
            r_lmin <= log_res;
        end
        if (i_cmd.den_latch) begin
            r_den <= log_num;
        end
        if (i_cmd.b0_latch) begin
            r_b0 <= edge_idx;
        end
        if (i_cmd.b1_latch) begin
            r_b1 <= (edge_idx < r_b0) ? r_b0 : edge_idx;
        end
    end

    // band sum, one bar read per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_issuing;
            if (i_cmd.sum_init) begin
                r_issuing <= 1'b1;
                r_idx <= r_b0;
                r_sum <= '0;
            end else begin
                if (r_issuing) begin
                    r_idx <= r_idx + CNT_W'(1);
                    if (r_idx == r_b1) begin
                        r_issuing <= 1'b0;
                    end
                end
                if (r_rd_vld) begin
                    r_sum <= r_sum + 23'(r_rdata);
                end
            end
        end
    end

    // result register, one strobe per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_result.band_level <= i_cmd.emit_err ? 16'd0 : div_q[15:0];
            r_result.status <= i_cmd.emit_err ? STATUS_ERR : STATUS_OK;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.is_query = (i_item.cmd == CMD_QUERY);
        o_stat.query_err = !i_item.spectrum_valid || (n_cur == '0) ||
                           (r_freq_low == 16'd0) || (r_freq_high <= r_freq_low);
        o_stat.log_done = log_done;
        o_stat.den_zero = (log_res == r_lmin);
        o_stat.div_done = div_done;
        o_stat.sum_done = !r_issuing && !r_rd_vld;
    end

    assign o_valid = r_valid;
    assign o_result = r_result;

endmodule

// File: design/lbsa_ctrl.sv
// query sequencer: logarithms, index divisions, band sum and mean
module lbsa_ctrl
    import lbsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_ctl_stat i_stat,
    output t_ctl_cmd  o_cmd,
    output logic      o_busy
);

    t_state r_state;
    t_state n_state;
    logic   r_sum_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.log_sel = LOG_FMIN;
        o_cmd.div_sel = DIV_EDGE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (!i_stat.is_query) begin
                        o_cmd.wr_bar = 1'b1;
                    end else if (i_stat.query_err) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.emit_err = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        o_cmd.log_start = 1'b1;
                        o_cmd.log_sel = LOG_FMIN;
                        n_state = S_LMIN;
                    end
                end
            end
            S_LMIN: begin
                if (i_stat.log_done) begin
                    o_cmd.lmin_latch = 1'b1;
                    o_cmd.log_start = 1'b1;
                    o_cmd.log_sel = LOG_FMAX;
                    n_state = S_LMAX;
                end
            end
            S_LMAX: begin
                if (i_stat.log_done) begin
                    if (i_stat.den_zero) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.emit_err = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.den_latch = 1'b1;
                        o_cmd.log_start = 1'b1;
                        o_cmd.log_sel = LOG_LO;
                        n_state = S_LLO;
                    end
                end
            end
            S_LLO: begin
                if (i_stat.log_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DLO;
                end
            end
            S_DLO: begin
                if (i_stat.div_done) begin
                    o_cmd.b0_latch = 1'b1;
                    o_cmd.log_start = 1'b1;
                    o_cmd.log_sel = LOG_HI;
                    n_state = S_LHI;
                end
            end
            S_LHI: begin
                if (i_stat.log_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DHI;
                end
            end
            S_DHI: begin
                if (i_stat.div_done) begin
                    o_cmd.b1_latch = 1'b1;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum_init = r_sum_first;
                if (i_stat.sum_done && !r_sum_first) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel = DIV_MEAN;
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.div_sel = DIV_MEAN;
                if (i_stat.div_done) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // first cycle in the sum state starts the bar reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_first <= 1'b0;
        end else begin
            r_sum_first <= (r_state == S_DHI) && i_stat.div_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: design/log_band_spectrum_average.sv
// top level of the log band spectrum average block
// A load (cmd 0) writes one bar and gives no result; busy stays low. A query
// (cmd 1) gives exactly one result, shown for one cycle on o_valid, which the
// receiver must take then; it cannot stall the block. An error query (invalid
// spectrum, zero bar count or unusable frequency setup) returns band_level 0
// and status 1 in the cycle after start. A good query runs four logarithms
// (16 squaring steps of three 32x32 partial products each) and three
// divisions (the two band edge indices and the mean), and sums the band
// through the bar read pipeline before the mean. Busy stays high for the
// whole of a good query. The user must write configuration through the plain
// write port only while busy is low; the block itself does not enforce this.
module log_band_spectrum_average
    import lbsa_pkg::*;
#(
    parameter int unsigned MAX_BARS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    output logic                  o_valid,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctl_cmd  ctl_cmd;
    t_ctl_stat ctl_stat;

    lbsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (ctl_stat),
        .o_cmd   (ctl_cmd),
        .o_busy  (busy)
    );

    lbsa_datapath #(
        .MAX_BARS (MAX_BARS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (ctl_cmd),
        .o_stat     (ctl_stat),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule
